@@ rtl/mits_pkg.sv @@
// shared types and constants for the moving-inversions memory test sequencer
// no dependencies; used by the top level and its port checker

package mits_pkg;

  localparam int unsigned WordAddrBits  = 28;
  localparam int unsigned MaxLineWords  = 32;
  localparam int unsigned AddrW         = WordAddrBits;
  localparam int unsigned DataW         = 64;
  localparam int unsigned CfgIdxW       = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBase    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLength  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSpan    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLine    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPattern = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRotate  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSweep   = 3'd6;

  // input op codes
  localparam logic OpStart = 1'b0;
  localparam logic OpBeat  = 1'b1;

  // test phases
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhFill = 2'd1;
  localparam logic [1:0] PhAsc  = 2'd2;
  localparam logic [1:0] PhDesc = 2'd3;

  localparam logic [5:0] LastPass = 6'd63;

  typedef struct packed {
    logic             op;
    logic [DataW-1:0] read_data;
  } mits_in_t;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
    logic             check_read;
    logic             done_res;
    logic             failed;
    logic [AddrW-1:0] fail_address;
  } mits_res_t;

endpackage

@@ rtl/moving_inversions_mem_test_seq.sv @@
// moving-inversions memory test sequencer, top level
// depends on mits_pkg; checked by mits_checker through a bind
//
//   channel  | direction | handshake               | beat
//   ---------+-----------+-------------------------+------------------------
//   in       | input     | in_valid_i / in_stall_o | mits_in_t (op, read data)
//   out      | output    | out_valid_o/out_stall_i | mits_res_t (next access)
//   cfg      | input     | cfg_we_i                | index + 64-bit data
//
// one beat per cycle while in_stall_o is low: each accepted input beat writes its
// result into the output buffer at the next edge, behind any result still waiting.
// the two-entry output buffer takes a new beat while one result still waits;
// in_stall_o rises only when both entries are full.
// reset clears the test state to done and loads the register defaults.

module moving_inversions_mem_test_seq
  import mits_pkg::*;
#(
  parameter int unsigned MAX_LINE_WORDS = MaxLineWords
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mits_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mits_res_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DataW-1:0]    cfg_wdata_i
);

  localparam int unsigned WicW = $clog2(MAX_LINE_WORDS + 1);
  localparam logic [WicW-1:0] LineMax = WicW'(MAX_LINE_WORDS);

  function automatic logic [DataW-1:0] rotl1(input logic [DataW-1:0] x);
    rotl1 = {x[DataW-2:0], x[DataW-1]};
  endfunction

  function automatic logic [DataW-1:0] rotr1(input logic [DataW-1:0] x);
    rotr1 = {x[0], x[DataW-1:1]};
  endfunction

  // configuration registers
  logic [AddrW-1:0] cfg_base_q, cfg_len_q, cfg_span_q;
  logic [5:0]       cfg_line_q;
  logic [DataW-1:0] cfg_pat_q;
  logic             cfg_rot_q, cfg_sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= '0;
      cfg_len_q   <= '0;
      cfg_span_q  <= AddrW'(8);
      cfg_line_q  <= 6'd8;
      cfg_pat_q   <= '0;
      cfg_rot_q   <= 1'b0;
      cfg_sweep_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBase:    cfg_base_q  <= cfg_wdata_i[AddrW-1:0];
        CfgLength:  cfg_len_q   <= cfg_wdata_i[AddrW-1:0];
        CfgSpan:    cfg_span_q  <= cfg_wdata_i[AddrW-1:0];
        CfgLine:    cfg_line_q  <= cfg_wdata_i[5:0];
        CfgPattern: cfg_pat_q   <= cfg_wdata_i;
        CfgRotate:  cfg_rot_q   <= cfg_wdata_i[0];
        CfgSweep:   cfg_sweep_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // run copies and test state
  logic [AddrW-1:0] run_base_q, run_len_q, run_span_q;
  logic [WicW-1:0]  run_line_q;
  logic [DataW-1:0] run_pat_q;
  logic             run_rot_q, run_sweep_q;
  logic [1:0]       phase_q, phase_d;
  logic [5:0]       pass_q, pass_d;
  logic [AddrW-1:0] cs_q, cs_d;
  logic [WicW-1:0]  wic_q, wic_d;
  logic [DataW-1:0] cp_q, cp_d, ev_q, ev_d;
  logic             cpend_q, cpend_d, fail_q, fail_d;
  logic [AddrW-1:0] pa_q, pa_d;

  // output buffer
  mits_res_t  s0_q, s0_d, s1_q, s1_d, res;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop, start;

  // effective run parameters and state ahead of the issue step
  logic [AddrW-1:0] r_base, r_len, r_span, cs;
  logic [WicW-1:0]  r_line, cfg_line_c, wic, cw;
  logic [DataW-1:0] r_pat, cp, ev;
  logic             r_rot, r_sweep, fl, cpend;
  logic [1:0]       ph;
  logic [5:0]       pi;
  logic [AddrW-1:0] pa, rem;
  logic [AddrW:0]   nxt_cs;
  logic             has_next;

  // issue step
  logic             do_fa, do_d, chk;
  logic [1:0]       fa_ph;
  logic [AddrW-1:0] fa_cs, d_cs, acc_cs;
  logic [WicW-1:0]  fa_off, d_off, acc_off;
  logic [DataW-1:0] fa_b, rp, wd;
  logic [AddrW+1:0] sum;
  logic [AddrW-1:0] acc_addr;

  assign push        = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;
  assign start       = in_data_i.op == OpStart;
  assign in_stall_o  = cnt_q == 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = s0_q;

  always_comb begin
    if (cfg_line_q == 6'd0) begin
      cfg_line_c = WicW'(1);
    end else if (32'(cfg_line_q) > MAX_LINE_WORDS) begin
      cfg_line_c = LineMax;
    end else begin
      cfg_line_c = WicW'(cfg_line_q);
    end
  end

  always_comb begin
    r_base  = run_base_q;
    r_len   = run_len_q;
    r_span  = run_span_q;
    r_line  = run_line_q;
    r_pat   = run_pat_q;
    r_rot   = run_rot_q;
    r_sweep = run_sweep_q;
    ph      = phase_q;
    pi      = pass_q;
    cs      = cs_q;
    wic     = wic_q;
    cp      = cp_q;
    ev      = ev_q;
    fl      = fail_q;
    pa      = pa_q;
    cpend   = cpend_q;
    if (start) begin
      r_base  = cfg_base_q;
      r_len   = cfg_len_q;
      r_line  = cfg_line_c;
      r_span  = (cfg_span_q < AddrW'(cfg_line_c)) ? AddrW'(cfg_line_c) : cfg_span_q;
      r_pat   = cfg_pat_q;
      r_sweep = cfg_sweep_q;
      r_rot   = cfg_sweep_q || cfg_rot_q;
      fl      = 1'b0;
      cpend   = 1'b0;
      pa      = '0;
      ev      = '0;
      pi      = '0;
      cs      = '0;
      wic     = '0;
      cp      = cfg_sweep_q ? DataW'(1) : cfg_pat_q;
      ph      = (cfg_len_q == '0) ? PhIdle : PhFill;
    end else if (ph != PhIdle && cpend && in_data_i.read_data != ev) begin
      fl = 1'b1;
      ph = PhIdle;
    end

    rem      = r_len - cs;
    cw       = (rem < AddrW'(r_line)) ? WicW'(rem) : r_line;
    nxt_cs   = {1'b0, cs} + {1'b0, r_span};
    has_next = nxt_cs < {1'b0, r_len};

    do_fa  = 1'b0;
    do_d   = 1'b0;
    fa_ph  = ph;
    fa_cs  = cs;
    fa_off = wic;
    fa_b   = cp;
    d_cs   = cs;
    d_off  = wic - WicW'(1);
    pass_d = pi;
    case (ph)
      PhFill, PhAsc: begin
        if (wic < cw) begin
          do_fa = 1'b1;
        end else if (has_next) begin
          do_fa  = 1'b1;
          fa_cs  = nxt_cs[AddrW-1:0];
          fa_off = '0;
        end else if (ph == PhFill) begin
          do_fa  = 1'b1;
          fa_ph  = PhAsc;
          fa_cs  = '0;
          fa_off = '0;
          fa_b   = r_sweep ? (DataW'(1) << pi) : r_pat;
        end else begin
          do_d  = 1'b1;
          d_off = cw - WicW'(1);
        end
      end
      PhDesc: begin
        if (wic != '0) begin
          do_d = 1'b1;
        end else if (cs >= r_span) begin
          do_d  = 1'b1;
          d_cs  = cs - r_span;
          d_off = r_line - WicW'(1);
        end else if (r_sweep && pi != LastPass) begin
          pass_d = pi + 6'd1;
          do_fa  = 1'b1;
          fa_ph  = PhFill;
          fa_cs  = '0;
          fa_off = '0;
          fa_b   = DataW'(1) << pass_d;
        end
      end
      default: ;
    endcase

    phase_d = PhIdle;
    cs_d    = cs;
    wic_d   = wic;
    cp_d    = cp;
    ev_d    = ev;
    rp      = r_rot ? rotr1(cp) : cp;
    acc_cs  = fa_cs;
    acc_off = fa_off;
    wd      = fa_b;
    chk     = 1'b0;
    if (do_fa) begin
      phase_d = fa_ph;
      cs_d    = fa_cs;
      wic_d   = fa_off + WicW'(1);
      cp_d    = r_rot ? rotl1(fa_b) : fa_b;
      if (fa_ph == PhAsc) begin
        ev_d = fa_b;
        wd   = ~fa_b;
        chk  = 1'b1;
      end
    end else if (do_d) begin
      phase_d = PhDesc;
      cs_d    = d_cs;
      wic_d   = d_off;
      cp_d    = rp;
      ev_d    = ~rp;
      acc_cs  = d_cs;
      acc_off = d_off;
      wd      = rp;
      chk     = 1'b1;
    end

    sum      = {2'b0, r_base} + {2'b0, acc_cs} + (AddrW+2)'(acc_off);
    acc_addr = sum[AddrW-1:0];

    res  = '0;
    fail_d = fl;
    if (do_fa || do_d) begin
      cpend_d        = chk;
      pa_d           = acc_addr;
      res.address    = acc_addr;
      res.write_data = wd;
      res.check_read = chk;
    end else begin
      cpend_d          = 1'b0;
      pa_d             = pa;
      res.done_res     = 1'b1;
      res.failed       = fl;
      res.fail_address = fl ? pa : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_base_q  <= '0;
      run_len_q   <= '0;
      run_span_q  <= AddrW'(1);
      run_line_q  <= WicW'(1);
      run_pat_q   <= '0;
      run_rot_q   <= 1'b0;
      run_sweep_q <= 1'b0;
      phase_q     <= PhIdle;
      pass_q      <= '0;
      cs_q        <= '0;
      wic_q       <= '0;
      cp_q        <= '0;
      ev_q        <= '0;
      cpend_q     <= 1'b0;
      fail_q      <= 1'b0;
      pa_q        <= '0;
    end else if (push) begin
      run_base_q  <= r_base;
      run_len_q   <= r_len;
      run_span_q  <= r_span;
      run_line_q  <= r_line;
      run_pat_q   <= r_pat;
      run_rot_q   <= r_rot;
      run_sweep_q <= r_sweep;
      phase_q     <= phase_d;
      pass_q      <= pass_d;
      cs_q        <= cs_d;
      wic_q       <= wic_d;
      cp_q        <= cp_d;
      ev_q        <= ev_d;
      cpend_q     <= cpend_d;
      fail_q      <= fail_d;
      pa_q        <= pa_d;
    end
  end

  // two-entry output buffer, head in s0
  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    s0_d  = s0_q;
    s1_d  = s1_q;
    if (pop && cnt_q == 2'd2) begin
      s0_d = s1_q;
    end else if ((pop || cnt_q == 2'd0) && push) begin
      s0_d = res;
    end
    if (push && !pop && cnt_q == 2'd1) begin
      s1_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

endmodule

@@ rtl/mits_checker.sv @@
// port-level checks for the moving-inversions memory test sequencer
// depends on mits_pkg; bound to moving_inversions_mem_test_seq below

module mits_checker
  import mits_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input mits_res_t out_data_o
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // an accepted input beat always shows a result at the next edge
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // a done result carries no access
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |->
      out_data_o.address == '0 && out_data_o.write_data == '0 && !out_data_o.check_read)
    else $error("done result carries an access");

  // failure is only reported on a done result
  a_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.failed |-> out_data_o.done_res)
    else $error("failure flagged during an access");

  // fail address is clear unless a failure is reported
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.failed |-> out_data_o.fail_address == '0)
    else $error("fail address set without a failure");

endmodule

bind moving_inversions_mem_test_seq mits_checker u_mits_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
